[hdl/ptst_pkg.sv]
`default_nettype none

package ptst_pkg;

    // Table geometry and ID numbering.
    localparam int SLOTS   = 5;
    localparam int ID_BASE = 10000;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths.
    localparam int ID_W     = 32;
    localparam int NOW_W    = 32;
    localparam int TIME_W   = 16;
    localparam int PERIOD_W = 16;
    localparam int PRIO_W   = 2;
    localparam int MODE_W   = 2;
    localparam int KIND_W   = 2;

    // Stream packing: input tdata holds now_time, period_ms, prio_level, slot_id_in.
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 56;

    // Item modes carried in s_tuser.
    localparam logic [MODE_W-1:0] MODE_REG   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNREG = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    // Result kinds carried in m_tuser.
    localparam logic [KIND_W-1:0] KIND_REG   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNREG = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE  = 2'd2;

    // Status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPLY,
        ST_FIRE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // latch the accepted item and restart the scan
        logic scan;      // evaluate the slot at the current index
        logic idx_clr;   // rewind the index for the fire pass
        logic reply;     // emit the register or unregister reply and commit it
        logic fire_adv;  // step the fire pass; emits when the slot fires
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic              idx_last;
        logic [MODE_W-1:0] mode;
        logic              hit;
        logic              out_free;
    } dp_stat_t;

    // First ID candidate base for a priority; priority zero never registers.
    function automatic logic [ID_W-1:0] base_id(input logic [PRIO_W-1:0] prio);
        logic [ID_W-1:0] base;
        case (prio)
            2'd1:    base = ID_W'(ID_BASE);
            2'd2:    base = ID_W'(ID_BASE * 2);
            2'd3:    base = ID_W'(ID_BASE * 3);
            default: base = '0;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

[hdl/periodic_timeout_slot_table.sv]
// Periodic timeout slot table with five slots.
// Input channel (s_): one transfer per item. s_tuser carries the mode
// (register, unregister, tick); s_tdata carries now_time, period_ms,
// prio_level and slot_id_in. Result channel (m_): s_tuser's counterpart
// m_tuser carries the result kind, m_tdata the ID, lag and status, and
// m_tlast marks the final result of an item.
// Each accepted item is handled alone: it is accepted, then the slot
// table is scanned at one slot per cycle, then either a reply is issued
// or, for a tick, a fire pass runs at one cycle per slot while no firing
// slot waits on a stalled receiver. A register or unregister item yields
// one result. A tick yields one result per firing slot; a tick where
// nothing fires yields nothing. An item of the unused mode yields nothing.
// The table is read at a single index, which the scan and fire pass step.
// The result register holds one result, so the next item is accepted while
// the previous result still waits; when the receiver stalls, the reply or
// a firing step waits for the result register to free; nothing is lost.
// Reset (aresetn low at a clock edge) frees every slot and empties the
// result register; it takes effect at that edge with no clearing pass.
`default_nettype none

module periodic_timeout_slot_table (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // s_tdata, lowest bit up: now_time[31:0], period_ms[47:32],
    // prio_level[49:48], slot_id_in[81:50], zero fill[87:82].
    input  wire  [ptst_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: mode[1:0].
    input  wire  [ptst_pkg::MODE_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // m_tdata, lowest bit up: slot_id_out[31:0], lag_ms[47:32],
    // status[48], zero fill[55:49].
    output logic [ptst_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: kind[1:0].
    output logic [ptst_pkg::KIND_W-1:0]     m_tuser,
    output logic                            m_tlast
);

    // Commands from the controller and status back from the datapath.
    ptst_pkg::dp_cmd_t  cmd;
    ptst_pkg::dp_stat_t stat;

    // The controller sequences accept, scan, reply and fire passes.
    ptst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the slot table, the scan registers and the
    // result register that drives the result channel.
    ptst_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

[hdl/ptst_ctrl.sv]
`default_nettype none

module ptst_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  ptst_pkg::dp_stat_t stat,
    output ptst_pkg::dp_cmd_t  cmd
);

    ptst_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptst_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ptst_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ptst_pkg::ST_SCAN;
                end
            end
            ptst_pkg::ST_SCAN: begin
                if (stat.idx_last) begin
                    if (stat.mode == ptst_pkg::MODE_REG ||
                        stat.mode == ptst_pkg::MODE_UNREG) begin
                        state_next = ptst_pkg::ST_REPLY;
                    end else if (stat.mode == ptst_pkg::MODE_TICK) begin
                        state_next = ptst_pkg::ST_FIRE;
                    end else begin
                        state_next = ptst_pkg::ST_IDLE;
                    end
                end
            end
            ptst_pkg::ST_REPLY: begin
                if (stat.out_free) begin
                    state_next = ptst_pkg::ST_IDLE;
                end
            end
            ptst_pkg::ST_FIRE: begin
                if ((!stat.hit || stat.out_free) && stat.idx_last) begin
                    state_next = ptst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ptst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ptst_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ptst_pkg::ST_SCAN: begin
                cmd.scan    = 1'b1;
                cmd.idx_clr = stat.idx_last;
            end
            ptst_pkg::ST_REPLY: begin
                cmd.reply = stat.out_free;
            end
            ptst_pkg::ST_FIRE: begin
                cmd.fire_adv = !stat.hit || stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/ptst_dp.sv]
`default_nettype none

module ptst_dp (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire  [ptst_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire  [ptst_pkg::MODE_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [ptst_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [ptst_pkg::KIND_W-1:0]         m_tuser,
    output logic                                m_tlast,
    input  ptst_pkg::dp_cmd_t                   cmd,
    output ptst_pkg::dp_stat_t                  stat
);

    // Slot table.
    logic [ptst_pkg::ID_W-1:0]     slot_ident_reg  [ptst_pkg::SLOTS];
    logic [ptst_pkg::PERIOD_W-1:0] slot_period_reg [ptst_pkg::SLOTS];
    logic [ptst_pkg::PRIO_W-1:0]   slot_prio_reg   [ptst_pkg::SLOTS];
    logic [ptst_pkg::TIME_W-1:0]   slot_last_reg   [ptst_pkg::SLOTS];

    // Latched item.
    logic [ptst_pkg::MODE_W-1:0]   mode_reg;
    logic [ptst_pkg::TIME_W-1:0]   now_reg;
    logic [ptst_pkg::PERIOD_W-1:0] period_reg;
    logic [ptst_pkg::PRIO_W-1:0]   prio_reg;
    logic [ptst_pkg::ID_W-1:0]     id_in_reg;

    // Scan state.
    logic [ptst_pkg::SLOT_W-1:0]   idx_reg, idx_next;
    logic                          free_found_reg;
    logic [ptst_pkg::SLOT_W-1:0]   free_idx_reg;
    logic [ptst_pkg::ID_W-1:0]     top_reg;
    logic                          match_found_reg;
    logic [ptst_pkg::SLOT_W-1:0]   match_idx_reg;
    logic [ptst_pkg::SLOTS-1:0]    fire_mask_reg;

    // Output register.
    logic                          m_tvalid_reg;
    logic [ptst_pkg::KIND_W-1:0]   out_kind_reg,   out_kind_next;
    logic [ptst_pkg::ID_W-1:0]     out_id_reg,     out_id_next;
    logic [ptst_pkg::PERIOD_W-1:0] out_lag_reg,    out_lag_next;
    logic                          out_status_reg, out_status_next;
    logic                          out_last_reg,   out_last_next;

    logic [ptst_pkg::ID_W-1:0]     cur_ident;
    logic                          cur_valid;
    logic [ptst_pkg::TIME_W-1:0]   elapsed;
    logic [ptst_pkg::PERIOD_W-1:0] lag;
    logic                          fire_now;
    logic                          more_fires;
    logic                          reg_refuse;
    logic                          unreg_fail;
    logic [ptst_pkg::ID_W-1:0]     new_id;
    logic                          hit;
    logic                          emit;
    logic                          out_free;
    logic                          reg_commit;
    logic                          unreg_commit;

    assign cur_ident = slot_ident_reg[idx_reg];
    assign cur_valid = (cur_ident != '0);
    assign elapsed   = now_reg - slot_last_reg[idx_reg];
    assign lag       = elapsed - slot_period_reg[idx_reg];
    assign fire_now  = cur_valid && (elapsed >= slot_period_reg[idx_reg]);
    assign hit       = fire_mask_reg[idx_reg];

    always_comb begin
        more_fires = 1'b0;
        for (int i = 0; i < ptst_pkg::SLOTS; i++) begin
            if (ptst_pkg::SLOT_W'(i) > idx_reg && fire_mask_reg[i]) begin
                more_fires = 1'b1;
            end
        end
    end

    assign new_id       = top_reg + ptst_pkg::ID_W'(1);
    assign reg_refuse   = (prio_reg == '0) || !free_found_reg || (top_reg == '1);
    assign unreg_fail   = (id_in_reg == '0) || !match_found_reg;
    assign reg_commit   = cmd.reply && (mode_reg == ptst_pkg::MODE_REG) && !reg_refuse;
    assign unreg_commit = cmd.reply && (mode_reg == ptst_pkg::MODE_UNREG) && !unreg_fail;
    assign emit         = cmd.reply || (cmd.fire_adv && hit);
    assign out_free     = !m_tvalid_reg || m_tready;

    assign stat.idx_last = (idx_reg == ptst_pkg::SLOT_W'(ptst_pkg::SLOTS - 1));
    assign stat.mode     = mode_reg;
    assign stat.hit      = hit;
    assign stat.out_free = out_free;

    always_comb begin
        if (cmd.load || cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.scan || cmd.fire_adv) begin
            idx_next = idx_reg + ptst_pkg::SLOT_W'(1);
        end else begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item latch and per-slot scan accumulation.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg        <= s_tuser;
            now_reg         <= s_tdata[ptst_pkg::TIME_W-1:0];
            period_reg      <= s_tdata[47:32];
            prio_reg        <= s_tdata[49:48];
            id_in_reg       <= s_tdata[81:50];
            top_reg         <= ptst_pkg::base_id(s_tdata[49:48]);
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
        end else if (cmd.scan) begin
            if (!cur_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            if (cur_valid && slot_prio_reg[idx_reg] == prio_reg && cur_ident > top_reg) begin
                top_reg <= cur_ident;
            end
            if (cur_ident == id_in_reg && !match_found_reg) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= idx_reg;
            end
            fire_mask_reg[idx_reg] <= fire_now;
        end
    end

    // Slot IDs clear at reset; zero marks a free slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ptst_pkg::SLOTS; i++) begin
                slot_ident_reg[i] <= '0;
            end
        end else if (reg_commit) begin
            slot_ident_reg[free_idx_reg] <= new_id;
        end else if (unreg_commit) begin
            slot_ident_reg[match_idx_reg] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (reg_commit) begin
            slot_period_reg[free_idx_reg] <= period_reg;
            slot_prio_reg[free_idx_reg]   <= prio_reg;
            slot_last_reg[free_idx_reg]   <= now_reg;
        end else if (cmd.fire_adv && hit) begin
            slot_last_reg[idx_reg] <= now_reg;
        end
    end

    always_comb begin
        if (cmd.reply) begin
            out_lag_next  = '0;
            out_last_next = 1'b1;
            if (mode_reg == ptst_pkg::MODE_REG) begin
                out_kind_next   = ptst_pkg::KIND_REG;
                out_id_next     = reg_refuse ? '0 : new_id;
                out_status_next = reg_refuse ? ptst_pkg::STATUS_FAIL : ptst_pkg::STATUS_OK;
            end else begin
                out_kind_next   = ptst_pkg::KIND_UNREG;
                out_id_next     = id_in_reg;
                out_status_next = unreg_fail ? ptst_pkg::STATUS_FAIL : ptst_pkg::STATUS_OK;
            end
        end else begin
            out_kind_next   = ptst_pkg::KIND_FIRE;
            out_id_next     = cur_ident;
            out_lag_next    = lag;
            out_status_next = ptst_pkg::STATUS_OK;
            out_last_next   = !more_fires;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_kind_reg   <= out_kind_next;
            out_id_reg     <= out_id_next;
            out_lag_reg    <= out_lag_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = ptst_pkg::M_TDATA_W'({out_status_reg, out_lag_reg, out_id_reg});

`ifndef NO_ASSERTIONS
    // A waiting result is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !emit)
        else $error("result register overwritten while stalled");

    // Replies are only produced for register and unregister items.
    a_reply_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.reply |-> (mode_reg == ptst_pkg::MODE_REG || mode_reg == ptst_pkg::MODE_UNREG))
        else $error("reply issued for a tick or unused item");

    // A committed registration leaves a nonzero ID in the chosen slot.
    a_reg_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        reg_commit |=> (slot_ident_reg[$past(free_idx_reg)] != '0))
        else $error("registered slot left free");

    // A fire result always has a live slot behind it.
    a_fire_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fire_adv && hit) |-> cur_valid)
        else $error("fire emitted for a free slot");
`endif

endmodule

`default_nettype wire
